// ===== hdl/byte_deque_with_low_watermark_unit_assert.svh =====
// Assertion helpers for the byte deque block.
// Each macro writes one labelled concurrent assertion on the given clock and
// active-low reset, and reports through $error.
`ifndef BYTE_DEQUE_WITH_LOW_WATERMARK_UNIT_ASSERT_SVH
`define BYTE_DEQUE_WITH_LOW_WATERMARK_UNIT_ASSERT_SVH

// Same-cycle implication.
`define BDQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BDQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and fixed field widths of the byte deque block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

  localparam int CMD_W       = 2;
  localparam int BYTE_W      = 8;
  localparam int GET_W       = 7;
  localparam int STATUS_W    = 2;
  localparam int QSIZE_W     = 11;
  localparam int QSIZE_RESET = 1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_POST_BACK  = 2'd0,
    CMD_POST_FRONT = 2'd1,
    CMD_GET        = 2'd2,
    CMD_NOP        = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE   = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_EMPTY  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_GET
  } state_e;

  // Per-cycle commands from the sequencer to the pointer unit
  typedef struct packed {
    logic cfg_load;
    logic post_back;
    logic post_front;
    logic get_start;
    logic rd_step;
  } ptr_op_t;

endpackage

`default_nettype wire

// ===== hdl/bdq_ram.sv =====
// ----------------------------------------------------------------------------
// bdq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data between reads
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/bdq_ptr_unit.sv =====
// ----------------------------------------------------------------------------
// bdq_ptr_unit
// Pointers, effective size, free count and low watermark of the deque.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdq_ptr_unit #(
  parameter int DEPTH   = 1024,
  parameter int MAX_GET = 64,
  localparam int PTR_W  = $clog2(DEPTH),
  localparam int CNT_W  = $clog2(DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bdq_pkg::ptr_op_t              op_i,
  input  logic [bdq_pkg::QSIZE_W-1:0]   cfg_wdata_i,
  input  logic [bdq_pkg::GET_W-1:0]     get_count_i,
  output logic [PTR_W-1:0]              wr_addr_o,
  output logic [PTR_W-1:0]              front_addr_o,
  output logic [PTR_W-1:0]              rd_addr_o,
  output logic                          full_o,
  output logic [bdq_pkg::GET_W-1:0]     get_n_o,
  output logic [bdq_pkg::QSIZE_W-1:0]   free_nxt_o,
  output logic [bdq_pkg::QSIZE_W-1:0]   low_nxt_o
);

  import bdq_pkg::*;

  localparam int EXT_W = (CNT_W > QSIZE_W) ? CNT_W : QSIZE_W;
  localparam logic [EXT_W-1:0] DEPTH_X   = EXT_W'(DEPTH);
  localparam logic [CNT_W-1:0] RESET_EFF =
    CNT_W'((QSIZE_RESET > DEPTH) ? DEPTH : QSIZE_RESET);
  localparam logic [GET_W-1:0] MAX_GET_C = GET_W'(MAX_GET);

  logic [CNT_W-1:0] eff_q, eff_d;
  logic [CNT_W-1:0] free_q, free_d;
  logic [CNT_W-1:0] low_q, low_d;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;

  logic [EXT_W-1:0] cfg_x;
  logic [CNT_W-1:0] eff_new;
  logic [GET_W-1:0] want;
  logic [CNT_W-1:0] avail;
  logic [CNT_W-1:0] free_dec;
  logic [CNT_W-1:0] wr_inc;
  logic [CNT_W-1:0] rd_inc;
  logic [PTR_W-1:0] wr_wrap;
  logic [PTR_W-1:0] rd_wrap;
  logic [PTR_W-1:0] front;
  logic             post;

  // Saturate the written size to 1..DEPTH
  always_comb begin
    cfg_x = EXT_W'(cfg_wdata_i);
    if (cfg_x == '0) begin
      eff_new = CNT_W'(1);
    end else if (cfg_x > DEPTH_X) begin
      eff_new = CNT_W'(DEPTH);
    end else begin
      eff_new = CNT_W'(cfg_x);
    end
  end

  always_comb begin
    want     = (get_count_i > MAX_GET_C) ? MAX_GET_C : get_count_i;
    avail    = eff_q - free_q;
    get_n_o  = (EXT_W'(want) < EXT_W'(avail)) ? want : GET_W'(avail);
    free_dec = free_q - CNT_W'(1);
    post     = op_i.post_back || op_i.post_front;

    wr_inc   = CNT_W'(wr_ptr_q) + CNT_W'(1);
    rd_inc   = CNT_W'(rd_ptr_q) + CNT_W'(1);
    wr_wrap  = (wr_inc >= eff_q) ? '0 : wr_inc[PTR_W-1:0];
    rd_wrap  = (rd_inc >= eff_q) ? '0 : rd_inc[PTR_W-1:0];
    front    = (rd_ptr_q == '0) ? PTR_W'(eff_q - CNT_W'(1))
                                : rd_ptr_q - PTR_W'(1);
  end

  always_comb begin
    eff_d    = eff_q;
    free_d   = free_q;
    low_d    = low_q;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (op_i.cfg_load) begin
      eff_d    = eff_new;
      free_d   = eff_new;
      low_d    = eff_new;
      wr_ptr_d = '0;
      rd_ptr_d = '0;
    end else begin
      if (post) begin
        free_d = free_dec;
        low_d  = (free_dec < low_q) ? free_dec : low_q;
      end else if (op_i.get_start) begin
        free_d = CNT_W'(EXT_W'(free_q) + EXT_W'(get_n_o));
      end
      if (op_i.post_back) begin
        wr_ptr_d = wr_wrap;
      end
      if (op_i.post_front) begin
        rd_ptr_d = front;
      end else if (op_i.rd_step) begin
        rd_ptr_d = rd_wrap;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_q    <= RESET_EFF;
      free_q   <= RESET_EFF;
      low_q    <= RESET_EFF;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      eff_q    <= eff_d;
      free_q   <= free_d;
      low_q    <= low_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  assign wr_addr_o    = wr_ptr_q;
  assign front_addr_o = front;
  assign rd_addr_o    = rd_ptr_q;
  assign full_o       = (free_q == '0);
  assign free_nxt_o   = QSIZE_W'(free_d);
  assign low_nxt_o    = QSIZE_W'(low_d);

endmodule

`default_nettype wire

// ===== hdl/byte_deque_with_low_watermark_unit.sv =====
// ----------------------------------------------------------------------------
// byte_deque_with_low_watermark_unit
// Circular byte queue with insert at the back or the front, bounded reads
// from the front, and free-count low watermark tracking.
// ----------------------------------------------------------------------------
// A post (back or front), an unused command, a rejected post and a get that
// reads nothing each give one result beat; such items are taken one per
// cycle for as long as the result side keeps up. A get that reads n bytes
// holds the input while it starts, makes the first read of the byte RAM,
// then moves one byte per cycle, paced by its single read port, while the
// result side keeps up; the next item is taken at the earliest in the cycle
// after the last byte has moved into the result register. The
// byte RAM needs no clearing pass after reset or resize. Writing queue_size
// (cfg_we_i) empties the queue, sizes it to the written value clamped to
// 1..DEPTH, and resets the watermark; write it only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "byte_deque_with_low_watermark_unit_assert.svh"

module byte_deque_with_low_watermark_unit #(
  parameter int DEPTH   = 1024,
  parameter int MAX_GET = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [bdq_pkg::QSIZE_W-1:0]   cfg_wdata_i,
  // command channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bdq_pkg::CMD_W-1:0]     cmd_i,
  input  logic [bdq_pkg::BYTE_W-1:0]    data_byte_i,
  input  logic [bdq_pkg::GET_W-1:0]     get_count_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bdq_pkg::STATUS_W-1:0]  status_o,
  output logic [bdq_pkg::BYTE_W-1:0]    data_out_o,
  output logic                          last_o,
  output logic [bdq_pkg::QSIZE_W-1:0]   free_count_o,
  output logic [bdq_pkg::QSIZE_W-1:0]   min_free_o
);

  import bdq_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);

  // sequencer state
  state_e           state_q, state_d;
  logic             pend_q, pend_d;          // RAM read in flight
  logic             pend_last_q, pend_last_d;
  logic [GET_W-1:0] remain_q, remain_d;      // reads still to issue

  // result register
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [BYTE_W-1:0]   data_q, data_d;
  logic                last_q, last_d;
  logic [QSIZE_W-1:0]  free_q, free_d;
  logic [QSIZE_W-1:0]  low_q, low_d;

  logic             out_free;
  logic             in_ready;
  logic             load_byte;
  logic             issue;
  logic             accept;
  logic             load_item;
  cmd_e             cmd;
  status_e          item_status;
  ptr_op_t          op;

  logic [PTR_W-1:0]   wr_addr, front_addr, rd_addr;
  logic               full;
  logic [GET_W-1:0]   get_n;
  logic [QSIZE_W-1:0] free_nxt, low_nxt;
  logic [BYTE_W-1:0]  ram_rdata;

  assign cmd = cmd_e'(cmd_i);

  // --------------------------------------------------------------------------
  // Pointer unit and byte store
  // --------------------------------------------------------------------------
  bdq_ptr_unit #(
    .DEPTH   (DEPTH),
    .MAX_GET (MAX_GET)
  ) u_ptrs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op),
    .cfg_wdata_i  (cfg_wdata_i),
    .get_count_i  (get_count_i),
    .wr_addr_o    (wr_addr),
    .front_addr_o (front_addr),
    .rd_addr_o    (rd_addr),
    .full_o       (full),
    .get_n_o      (get_n),
    .free_nxt_o   (free_nxt),
    .low_nxt_o    (low_nxt)
  );

  // Writes only happen on accepted posts and reads only while a get runs,
  // so a read never meets a write of the same cycle; a read issued the cycle
  // after a write sees the new byte.
  bdq_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (op.post_back || op.post_front),
    .waddr_i (op.post_back ? wr_addr : front_addr),
    .wdata_i (data_byte_i),
    .re_i    (issue),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Sequencer outputs
  // --------------------------------------------------------------------------
  // The RAM read register doubles as a skid stage: a new read is issued only
  // when that register is empty or the byte already held there moves into the result register.
  always_comb begin
    out_free  = !out_valid_q || out_ready_i;
    in_ready  = 1'b0;
    load_byte = 1'b0;
    issue     = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready = out_free;
      end
      S_GET: begin
        load_byte = pend_q && out_free;
        issue     = (remain_q != '0) && (!pend_q || load_byte);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign in_ready_o = in_ready;
  assign accept     = in_valid_i && in_ready;

  always_comb begin
    op            = '0;
    op.cfg_load   = cfg_we_i;
    op.post_back  = accept && (cmd == CMD_POST_BACK) && !full;
    op.post_front = accept && (cmd == CMD_POST_FRONT) && !full;
    op.get_start  = accept && (cmd == CMD_GET) && (get_n != '0);
    op.rd_step    = issue;
  end

  // Status of a single-beat item
  always_comb begin
    case (cmd)
      CMD_POST_BACK,
      CMD_POST_FRONT: item_status = full ? STAT_FULL : STAT_DONE;
      CMD_GET:        item_status = (get_n == '0) ? STAT_EMPTY : STAT_DONE;
      default:        item_status = STAT_DONE;
    endcase
  end

  assign load_item = accept && !op.get_start;

  // --------------------------------------------------------------------------
  // Sequencer next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (op.get_start) begin
          state_d = S_GET;
        end
      end
      S_GET: begin
        if (load_byte && pend_last_q) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    remain_d    = remain_q;
    pend_d      = pend_q;
    pend_last_d = pend_last_q;
    if (op.get_start) begin
      remain_d = get_n;
    end else if (issue) begin
      remain_d = remain_q - GET_W'(1);
    end
    if (issue) begin
      pend_d      = 1'b1;
      pend_last_d = (remain_q == GET_W'(1));
    end else if (load_byte) begin
      pend_d = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  // Free count and watermark are the values after the whole item; during a
  // get they were already settled when the get started.
  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    data_d      = data_q;
    last_d      = last_q;
    free_d      = free_q;
    low_d       = low_q;
    if (load_item) begin
      out_valid_d = 1'b1;
      status_d    = item_status;
      data_d      = '0;
      last_d      = 1'b1;
      free_d      = free_nxt;
      low_d       = low_nxt;
    end else if (load_byte) begin
      out_valid_d = 1'b1;
      status_d    = STAT_DONE;
      data_d      = ram_rdata;
      last_d      = pend_last_q;
      free_d      = free_nxt;
      low_d       = low_nxt;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    data_q   <= data_d;
    last_q   <= last_d;
    free_q   <= free_d;
    low_q    <= low_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign data_out_o   = data_q;
  assign last_o       = last_q;
  assign free_count_o = free_q;
  assign min_free_o   = low_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `BDQ_ASSERT_IMP(a_low_not_above_free, clk_i, rst_ni, out_valid_o, min_free_o <= free_count_o, "watermark above free count")
  `BDQ_ASSERT_IMP(a_read_only_in_get, clk_i, rst_ni, pend_q, state_q == S_GET, "RAM read pending outside a get")
  `BDQ_ASSERT_NXT(a_last_byte_closes, clk_i, rst_ni, load_byte && pend_last_q, (state_q == S_IDLE) && out_valid_o && last_o, "final byte did not close the get")

endmodule

`default_nettype wire
